@@ rtl/core/smx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, constants and the exponent table for the row softmax.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int unsigned ROW_MAX     = 64;
  localparam int unsigned ROW_AW      = $clog2(ROW_MAX);
  localparam int unsigned FILL_W      = $clog2(ROW_MAX + 1);
  localparam int unsigned EXP_DEPTH   = 64;
  localparam int unsigned EXP_IDX_W   = $clog2(EXP_DEPTH);
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned SUM_W       = 23;
  localparam int unsigned INV_W       = 17;
  localparam int unsigned QUO_W       = 33;
  localparam int unsigned DIV_STEPS   = QUO_W;
  localparam int unsigned DIFF_W      = 13;
  localparam int unsigned PROD_W      = 30;
  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam logic [16:0] DIFF_LIMIT  = 17'd4096;
  localparam logic [63:0] LN2_Q32     = 64'd2977044472;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EXP,
    S_DRAIN,
    S_DIV,
    S_ORD,
    S_OMUL,
    S_OSEND
  } smx_state_e;

  typedef struct packed {
    logic              row_clr;
    logic              load;
    logic              exp_rd;
    logic              div_init;
    logic              div_step;
    logic              out_mul;
    logic [ROW_AW-1:0] addr;
  } smx_cmd_t;

  typedef logic [16:0] pow_table_t [EXP_DEPTH];

  // 2^-(i/EXP_DEPTH) in Q16, by a truncated series of exp(-i*ln2/EXP_DEPTH)
  function automatic pow_table_t build_pow();
    pow_table_t  tab;
    logic [63:0] a;
    logic [63:0] term;
    longint      acc;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      a    = (64'(i) * LN2_Q32) / EXP_DEPTH;
      term = 64'd1 << 32;
      acc  = longint'(term);
      for (int n = 1; n < 24; n++) begin
        term = ((term * a) >> 32) / 64'(n);
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      tab[i] = 17'((acc + 32768) >>> 16);
    end
    return tab;
  endfunction

  localparam pow_table_t POW_TABLE = build_pow();

endpackage

@@ rtl/core/smx_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/smx_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ctrl
// Row sequencer: load, exponent pass, reciprocal, output pass.
// ----------------------------------------------------------------------------
module smx_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_last_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_last_o,
  output logic [smx_pkg::ROW_AW-1:0] out_pos_o,
  input  logic                      pipe_busy_i,
  output smx_pkg::smx_cmd_t         cmd_o
);
  import smx_pkg::*;

  smx_state_e          state_q, state_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [ROW_AW-1:0]   idx_q, idx_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                in_acc, row_end, idx_end;

  assign in_acc  = (state_q == S_LOAD) && in_valid_i;
  assign row_end = in_last_i || (fill_q == FILL_W'(ROW_MAX - 1));
  assign idx_end = (FILL_W'(idx_q) == fill_q - FILL_W'(1));

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          fill_d = fill_q + FILL_W'(1);
          idx_d  = '0;
          if (row_end) state_d = S_EXP;
        end
      end
      S_EXP: begin
        idx_d = idx_q + ROW_AW'(1);
        if (idx_end) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        cnt_d = '0;
        if (!pipe_busy_i) state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + 6'd1;
        idx_d = '0;
        if (cnt_q == 6'(DIV_STEPS - 1)) state_d = S_ORD;
      end
      S_ORD:  state_d = S_OMUL;
      S_OMUL: state_d = S_OSEND;
      S_OSEND: begin
        if (out_ready_i) begin
          if (idx_end) begin
            state_d = S_LOAD;
            fill_d  = '0;
          end else begin
            idx_d   = idx_q + ROW_AW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o.addr     = idx_q;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_acc;
        cmd_o.addr = fill_q[ROW_AW-1:0];
      end
      S_EXP:   cmd_o.exp_rd   = 1'b1;
      S_DRAIN: cmd_o.div_init = !pipe_busy_i;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_ORD:   ;
      S_OMUL:  cmd_o.out_mul  = 1'b1;
      S_OSEND: begin
        out_valid_o   = 1'b1;
        cmd_o.row_clr = out_ready_i && idx_end;
      end
      default: ;
    endcase
  end

  assign out_last_o = idx_end;
  assign out_pos_o  = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fill_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(ROW_MAX)) else $error("fill count beyond row size");
  a_send_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OSEND |-> fill_q != '0) else $error("output with empty row");
  a_idx_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ORD || state_q == S_OSEND) |-> FILL_W'(idx_q) < fill_q)
    else $error("output index beyond row");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.row_clr |=> (state_q == S_LOAD && fill_q == '0))
    else $error("row not cleared after final request");
`endif

endmodule

@@ rtl/core/smx_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_dp
// Datapath: row and exponent stores, max tracking, exp pipe, divider, scaling.
// ----------------------------------------------------------------------------
module smx_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smx_pkg::smx_cmd_t          cmd_i,
  input  logic [smx_pkg::DATA_W-1:0] score_i,
  output logic                       pipe_busy_o,
  output logic [smx_pkg::DATA_W-1:0] prob_o
);
  import smx_pkg::*;

  logic signed [DATA_W-1:0] max_q;
  logic [SUM_W-1:0]         sum_q;
  logic [DATA_W-1:0]        row_rd, exp_rd;

  // exp pipe
  logic                     v1_q, v2_q;
  logic [ROW_AW-1:0]        a1_q, a2_q;
  logic                     big2_q;
  logic [PROD_W-1:0]        p_q;
  logic [16:0]              diff;
  logic [16:0]              pow_sel;
  logic [16:0]              shifted;
  logic [DATA_W-1:0]        exp_val;

  // divider and output scaling
  logic [SUM_W:0]           rem_q, rem_t;
  logic [QUO_W-1:0]         quo_q;
  logic [INV_W-1:0]         inv;
  logic [DATA_W+INV_W-1:0]  prod_q;
  logic [DATA_W+INV_W:0]    rnd;

  smx_ram #(.Width(DATA_W), .Depth(ROW_MAX)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (cmd_i.addr),
    .wdata_i (score_i),
    .raddr_i (cmd_i.addr),
    .rdata_o (row_rd)
  );

  smx_ram #(.Width(DATA_W), .Depth(ROW_MAX)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (v2_q),
    .waddr_i (a2_q),
    .wdata_i (exp_val),
    .raddr_i (cmd_i.addr),
    .rdata_o (exp_rd)
  );

  assign diff    = 17'(signed'({max_q[DATA_W-1], max_q})
                     - signed'({row_rd[DATA_W-1], row_rd}));
  assign pow_sel = POW_TABLE[p_q[23 -: EXP_IDX_W]];
  assign shifted = pow_sel >> p_q[PROD_W-1:24];
  always_comb begin
    if (big2_q) exp_val = '0;
    else if (shifted[16]) exp_val = '1;
    else exp_val = shifted[DATA_W-1:0];
  end

  assign pipe_busy_o = v1_q || v2_q;

  assign rem_t = {rem_q[SUM_W-1:0], quo_q[QUO_W-1]};
  assign inv   = quo_q[INV_W-1:0];
  assign rnd   = {1'b0, prod_q} + (DATA_W+INV_W+1)'(32768);
  assign prob_o = (|rnd[DATA_W+INV_W:32]) ? '1 : rnd[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'sh8000;
      sum_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      v1_q <= cmd_i.exp_rd;
      v2_q <= v1_q;
      if (cmd_i.row_clr) begin
        max_q <= 16'sh8000;
        sum_q <= '0;
      end else begin
        if (cmd_i.load && signed'(score_i) > max_q) max_q <= signed'(score_i);
        if (v2_q) sum_q <= sum_q + SUM_W'(exp_val);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= cmd_i.addr;
    a2_q   <= a1_q;
    big2_q <= diff > DIFF_LIMIT;
    p_q    <= PROD_W'(diff[DIFF_W-1:0] * LOG2E_Q16);
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= QUO_W'(1) << (QUO_W - 1);
    end else if (cmd_i.div_step) begin
      if (rem_t >= {1'b0, sum_q}) begin
        rem_q <= rem_t - {1'b0, sum_q};
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_t;
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd_i.out_mul) prod_q <= exp_rd * inv;
  end

`ifndef SYNTHESIS
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q)) else $error("exp pipe stage skipped");
  a_no_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> !pipe_busy_o) else $error("divide while sum open");
  a_max_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_clr |=> max_q == 16'sh8000 && sum_q == '0)
    else $error("row state not cleared");
`endif

endmodule

@@ rtl/core/softmax_row_fixed.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_row_fixed
// Fixed-point softmax over one row of Q8.8 scores, Q0.16 probabilities out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one score per request; tlast ends the row. A row of
//   64 elements ends on its own. Scores are taken one per cycle while the
//   block is loading; tready drops once the row has ended.
//   After the row ends the block reads the row store back through a
//   three-stage exponent pipe, then a bit-serial divider forms the
//   reciprocal of the sum.
//   Master stream then gives one probability per element in input order,
//   with its position; tlast marks the final one. Each output goes
//   through a store read, a scaling multiply and a send, which waits out any stall.
//   A stalled receiver holds the current result; nothing is lost.
//   The next row is accepted once the last result has been taken.
//   Reset (rst_ni low, asynchronous) empties the row and clears the
//   running maximum and sum; the stores need no clearing.
// ----------------------------------------------------------------------------
module softmax_row_fixed (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] score
  input  logic        s_axis_tlast,  // last_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] prob, [21:16] position, zero pad
  output logic        m_axis_tlast   // last_out
);
  import smx_pkg::*;

  smx_cmd_t          cmd;
  logic              pipe_busy;
  logic [ROW_AW-1:0] pos;
  logic [DATA_W-1:0] prob;

  smx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .out_pos_o   (pos),
    .pipe_busy_i (pipe_busy),
    .cmd_o       (cmd)
  );

  smx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .score_i     (s_axis_tdata),
    .pipe_busy_o (pipe_busy),
    .prob_o      (prob)
  );

  assign m_axis_tdata = {2'b00, pos, prob};

endmodule
